[rtl/rim_pkg.sv]
package rim_pkg;

    localparam int SIDE_W      = 8;
    localparam int CS_W        = 16;
    localparam int FRAC_BITS   = 14;
    localparam int PROD_W      = 25;
    localparam int CRD_W       = 12;
    localparam int BOX_W       = 12;
    localparam int IJ_W        = 12;
    localparam int MPROD_W     = 28;
    localparam int MAP_W       = 15;
    localparam int PIX_W       = 32;
    localparam int BG_W        = 24;
    localparam int OUT_W       = 9;
    localparam int ST_W        = 2;
    localparam int KIND_W      = 2;
    localparam int QUEUE_DEPTH = 4;
    localparam int REG_ADDR_W  = 5;
    localparam int REG_IDX_W   = 3;
    localparam int DATA_W      = 32;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    localparam logic [KIND_W-1:0] KIND_WRITE   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_MAP     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_OUTSIDE = 2'd2;

    localparam logic [ST_W-1:0] ST_COPY    = 2'd0;
    localparam logic [ST_W-1:0] ST_BG      = 2'd1;
    localparam logic [ST_W-1:0] ST_OUTSIDE = 2'd2;

    localparam logic [REG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_COSINE     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_SINE       = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_BACKGROUND = 3'd4;

    localparam logic [OUT_W-1:0] OUT_MAX = 9'h1FF;

    typedef struct packed {
        logic [SIDE_W-1:0]        w;
        logic [SIDE_W-1:0]        h;
        logic signed [CS_W-1:0]   cosv;
        logic signed [CS_W-1:0]   sinv;
        logic signed [CRD_W-1:0]  ox;
        logic signed [CRD_W-1:0]  oy;
        logic [BOX_W-1:0]         nw;
        logic [BOX_W-1:0]         nh;
        logic [PIX_W-1:0]         bg_pixel;
    } geom_t;

    typedef struct packed {
        logic [KIND_W-1:0]       kind;
        logic signed [IJ_W-1:0]  i;
        logic signed [IJ_W-1:0]  j;
        logic [PIX_W-1:0]        pixel;
    } qent_t;

    function automatic logic signed [31:0] q14_trunc(input logic signed [31:0] v);
        logic signed [31:0] bias;
        bias = (32'sd1 <<< FRAC_BITS) - 32'sd1;
        if (v < 32'sd0)
        begin
            q14_trunc = (v + bias) >>> FRAC_BITS;
        end
        else
        begin
            q14_trunc = v >>> FRAC_BITS;
        end
    endfunction

    function automatic logic signed [CRD_W-1:0] crd_min(
        input logic signed [CRD_W-1:0] a,
        input logic signed [CRD_W-1:0] b
    );
        crd_min = (a < b) ? a : b;
    endfunction

    function automatic logic signed [CRD_W-1:0] crd_max(
        input logic signed [CRD_W-1:0] a,
        input logic signed [CRD_W-1:0] b
    );
        crd_max = (a > b) ? a : b;
    endfunction

endpackage

[rtl/rim_queue.sv]
module rim_queue #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic             rd_valid,
    output logic [WIDTH-1:0] rdata,
    output logic             almost_full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_pop;

    assign rd_valid    = (count_reg != '0);
    assign rdata       = store_reg[rd_ptr_reg];
    assign almost_full = (count_reg >= CNT_W'(DEPTH - 1));
    assign do_pop      = pop && rd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

[rtl/rim_geom.sv]
module rim_geom #(
    parameter int MAX_SIDE = 128
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rim_pkg::REG_ADDR_W-1:0]      paddr,
    input  logic [rim_pkg::DATA_W-1:0]          pwdata,
    output logic [rim_pkg::DATA_W-1:0]          prdata,
    output rim_pkg::geom_t                      geom,
    output logic                                settle
);

    localparam int SIDE_W    = rim_pkg::SIDE_W;
    localparam int CS_W      = rim_pkg::CS_W;
    localparam int PROD_W    = rim_pkg::PROD_W;
    localparam int CRD_W     = rim_pkg::CRD_W;
    localparam int BOX_W     = rim_pkg::BOX_W;
    localparam int BG_W      = rim_pkg::BG_W;
    localparam int DATA_W    = rim_pkg::DATA_W;
    localparam int REG_IDX_W = rim_pkg::REG_IDX_W;
    localparam logic [1:0] SETTLE_CYCLES = 2'd3;

    logic [SIDE_W-1:0]        width_reg;
    logic [SIDE_W-1:0]        height_reg;
    logic signed [CS_W-1:0]   cos_reg;
    logic signed [CS_W-1:0]   sin_reg;
    logic [BG_W-1:0]          bg_reg;
    logic [1:0]               settle_reg;
    logic [1:0]               settle_next;
    logic                     cfg_we;
    logic [REG_IDX_W-1:0]     cfg_idx;

    logic [SIDE_W-1:0]        w_cl_next;
    logic [SIDE_W-1:0]        h_cl_next;
    logic [SIDE_W-1:0]        w_cl_reg;
    logic [SIDE_W-1:0]        h_cl_reg;
    logic signed [PROD_W-1:0] p_wc_reg;
    logic signed [PROD_W-1:0] p_ws_reg;
    logic signed [PROD_W-1:0] p_hc_reg;
    logic signed [PROD_W-1:0] p_hs_reg;

    logic signed [CRD_W-1:0]  x1_reg;
    logic signed [CRD_W-1:0]  y1_reg;
    logic signed [CRD_W-1:0]  x2_reg;
    logic signed [CRD_W-1:0]  y2_reg;
    logic signed [CRD_W-1:0]  x3_reg;
    logic signed [CRD_W-1:0]  y3_reg;

    logic signed [CRD_W-1:0]  minx_next;
    logic signed [CRD_W-1:0]  maxx_next;
    logic signed [CRD_W-1:0]  miny_next;
    logic signed [CRD_W-1:0]  maxy_next;
    logic signed [CRD_W-1:0]  minx_reg;
    logic signed [CRD_W-1:0]  miny_reg;
    logic [BOX_W-1:0]         nw_reg;
    logic [BOX_W-1:0]         nh_reg;

    assign cfg_we  = psel && penable && pwrite;
    assign cfg_idx = paddr[rim_pkg::REG_ADDR_W-1:2];

    always_comb
    begin
        unique case (cfg_idx)
            rim_pkg::REG_SRC_WIDTH:  prdata = DATA_W'(width_reg);
            rim_pkg::REG_SRC_HEIGHT: prdata = DATA_W'(height_reg);
            rim_pkg::REG_COSINE:     prdata = DATA_W'($unsigned(cos_reg));
            rim_pkg::REG_SINE:       prdata = DATA_W'($unsigned(sin_reg));
            rim_pkg::REG_BACKGROUND: prdata = DATA_W'(bg_reg);
            default:                 prdata = '0;
        endcase
    end

    always_comb
    begin
        settle_next = settle_reg;
        if (cfg_we)
        begin
            settle_next = SETTLE_CYCLES;
        end
        else if (settle_reg != 2'd0)
        begin
            settle_next = settle_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 8'd128;
            height_reg <= 8'd128;
            cos_reg    <= 16'sd16384;
            sin_reg    <= 16'sd0;
            bg_reg     <= '0;
            settle_reg <= SETTLE_CYCLES;
        end
        else
        begin
            settle_reg <= settle_next;
            if (cfg_we)
            begin
                unique case (cfg_idx)
                    rim_pkg::REG_SRC_WIDTH:  width_reg  <= pwdata[SIDE_W-1:0];
                    rim_pkg::REG_SRC_HEIGHT: height_reg <= pwdata[SIDE_W-1:0];
                    rim_pkg::REG_COSINE:     cos_reg    <= $signed(pwdata[CS_W-1:0]);
                    rim_pkg::REG_SINE:       sin_reg    <= $signed(pwdata[CS_W-1:0]);
                    rim_pkg::REG_BACKGROUND: bg_reg     <= pwdata[BG_W-1:0];
                    default:                 ;
                endcase
            end
        end
    end

    assign settle = (settle_reg != 2'd0);

    assign w_cl_next = (32'(width_reg) > MAX_SIDE) ? SIDE_W'(MAX_SIDE) : width_reg;
    assign h_cl_next = (32'(height_reg) > MAX_SIDE) ? SIDE_W'(MAX_SIDE) : height_reg;

    always_ff @(posedge clk)
    begin
        w_cl_reg <= w_cl_next;
        h_cl_reg <= h_cl_next;
        p_wc_reg <= $signed({1'b0, w_cl_next}) * cos_reg;
        p_ws_reg <= $signed({1'b0, w_cl_next}) * sin_reg;
        p_hc_reg <= $signed({1'b0, h_cl_next}) * cos_reg;
        p_hs_reg <= $signed({1'b0, h_cl_next}) * sin_reg;
    end

    always_ff @(posedge clk)
    begin
        x1_reg <= CRD_W'(rim_pkg::q14_trunc(32'(p_wc_reg)));
        y1_reg <= CRD_W'(-rim_pkg::q14_trunc(32'(p_ws_reg)));
        x2_reg <= CRD_W'(rim_pkg::q14_trunc(32'(p_hs_reg)));
        y2_reg <= CRD_W'(rim_pkg::q14_trunc(32'(p_hc_reg)));
        x3_reg <= CRD_W'(rim_pkg::q14_trunc(32'(p_wc_reg) + 32'(p_hs_reg)));
        y3_reg <= CRD_W'(rim_pkg::q14_trunc(32'(p_hc_reg) - 32'(p_ws_reg)));
    end

    always_comb
    begin
        minx_next = rim_pkg::crd_min(rim_pkg::crd_min('0, x1_reg),
                                     rim_pkg::crd_min(x2_reg, x3_reg));
        maxx_next = rim_pkg::crd_max(rim_pkg::crd_max('0, x1_reg),
                                     rim_pkg::crd_max(x2_reg, x3_reg));
        miny_next = rim_pkg::crd_min(rim_pkg::crd_min('0, y1_reg),
                                     rim_pkg::crd_min(y2_reg, y3_reg));
        maxy_next = rim_pkg::crd_max(rim_pkg::crd_max('0, y1_reg),
                                     rim_pkg::crd_max(y2_reg, y3_reg));
    end

    always_ff @(posedge clk)
    begin
        minx_reg <= minx_next;
        miny_reg <= miny_next;
        nw_reg   <= BOX_W'((CRD_W + 1)'(maxx_next) - (CRD_W + 1)'(minx_next));
        nh_reg   <= BOX_W'((CRD_W + 1)'(maxy_next) - (CRD_W + 1)'(miny_next));
    end

    always_comb
    begin
        geom.w        = w_cl_reg;
        geom.h        = h_cl_reg;
        geom.cosv     = cos_reg;
        geom.sinv     = sin_reg;
        geom.ox       = minx_reg;
        geom.oy       = miny_reg;
        geom.nw       = nw_reg;
        geom.nh       = nh_reg;
        geom.bg_pixel = {8'h00, bg_reg[7:0], bg_reg[15:8], bg_reg[23:16]};
    end

endmodule

[rtl/rim_front.sv]
module rim_front #(
    parameter int MAX_SIDE = 128,
    parameter int ADDR_W   = 14
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          command,
    input  logic [7:0]                    column,
    input  logic [7:0]                    line,
    input  logic [rim_pkg::PIX_W-1:0]     pixel_in,
    input  rim_pkg::geom_t                geom,
    input  logic                          settle,
    input  logic                          q_almost_full,
    output logic                          push,
    output rim_pkg::qent_t                push_ent,
    output logic [ADDR_W-1:0]             push_waddr
);

    localparam int BOX_W = rim_pkg::BOX_W;
    localparam int IJ_W  = rim_pkg::IJ_W;
    localparam int PIX_W = rim_pkg::PIX_W;

    logic              valid_reg;
    logic              cmd_reg;
    logic [7:0]        col_reg;
    logic [7:0]        line_reg;
    logic [PIX_W-1:0]  pix_reg;
    logic              accept;
    logic              in_range;
    logic              outside;

    assign busy   = settle || q_almost_full;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= command;
            col_reg  <= column;
            line_reg <= line;
            pix_reg  <= pixel_in;
        end
    end

    assign in_range = (32'(col_reg) < MAX_SIDE) && (32'(line_reg) < MAX_SIDE);
    assign outside  = (BOX_W'(col_reg) >= geom.nw) || (BOX_W'(line_reg) >= geom.nh);

    always_comb
    begin
        priority if (cmd_reg == rim_pkg::CMD_WRITE)
        begin
            push_ent.kind = rim_pkg::KIND_WRITE;
        end
        else if (outside)
        begin
            push_ent.kind = rim_pkg::KIND_OUTSIDE;
        end
        else
        begin
            push_ent.kind = rim_pkg::KIND_MAP;
        end
        push_ent.i     = geom.ox + IJ_W'(col_reg);
        push_ent.j     = geom.oy + IJ_W'(line_reg);
        push_ent.pixel = pix_reg;
    end

    assign push_waddr = ADDR_W'(ADDR_W'(line_reg) * ADDR_W'(MAX_SIDE) + ADDR_W'(col_reg));

    // drop writes that fall outside the store
    assign push = valid_reg && ((cmd_reg == rim_pkg::CMD_READ) || in_range);

endmodule

[rtl/rim_back.sv]
module rim_back #(
    parameter int MAX_SIDE = 128,
    parameter int ADDR_W   = 14
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    input  rim_pkg::qent_t                q_ent,
    input  logic [ADDR_W-1:0]             q_waddr,
    output logic                          q_pop,
    input  rim_pkg::geom_t                geom,
    output logic                          done,
    output logic [rim_pkg::PIX_W-1:0]     pixel_out,
    output logic [rim_pkg::ST_W-1:0]      status,
    output logic [rim_pkg::OUT_W-1:0]     out_width,
    output logic [rim_pkg::OUT_W-1:0]     out_height
);

    localparam int MPROD_W = rim_pkg::MPROD_W;
    localparam int MAP_W   = rim_pkg::MAP_W;
    localparam int PIX_W   = rim_pkg::PIX_W;
    localparam int ST_W    = rim_pkg::ST_W;
    localparam int KIND_W  = rim_pkg::KIND_W;
    localparam int BOX_W   = rim_pkg::BOX_W;
    localparam int OUT_W   = rim_pkg::OUT_W;
    localparam int WORDS   = MAX_SIDE * MAX_SIDE;

    logic [PIX_W-1:0] mem [WORDS];

    logic                      b1_valid_reg;
    logic [KIND_W-1:0]         b1_kind_reg;
    logic [ADDR_W-1:0]         b1_waddr_reg;
    logic [PIX_W-1:0]          b1_pixel_reg;
    logic signed [MPROD_W-1:0] b1_ic_reg;
    logic signed [MPROD_W-1:0] b1_js_reg;
    logic signed [MPROD_W-1:0] b1_is_reg;
    logic signed [MPROD_W-1:0] b1_jc_reg;

    logic                      b2_valid_reg;
    logic [KIND_W-1:0]         b2_kind_reg;
    logic [ADDR_W-1:0]         b2_waddr_reg;
    logic [PIX_W-1:0]          b2_pixel_reg;
    logic signed [MAP_W-1:0]   b2_nx_reg;
    logic signed [MAP_W-1:0]   b2_ny_reg;

    logic                      hit;
    logic [ADDR_W-1:0]         map_addr;
    logic [ADDR_W-1:0]         b3_addr_next;
    logic [ST_W-1:0]           b3_status_next;

    logic                      b3_valid_reg;
    logic                      b3_we_reg;
    logic                      b3_re_reg;
    logic [ADDR_W-1:0]         b3_addr_reg;
    logic [PIX_W-1:0]          b3_pixel_reg;
    logic [ST_W-1:0]           b3_status_reg;

    logic                      b4_valid_reg;
    logic [ST_W-1:0]           b4_status_reg;
    logic [PIX_W-1:0]          rdata_reg;

    logic                      done_reg;
    logic [PIX_W-1:0]          pixel_next;
    logic [PIX_W-1:0]          pixel_reg;
    logic [ST_W-1:0]           status_reg;
    logic [OUT_W-1:0]          width_reg;
    logic [OUT_W-1:0]          height_reg;

    assign q_pop = q_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg <= 1'b0;
            b2_valid_reg <= 1'b0;
            b3_valid_reg <= 1'b0;
            b3_we_reg    <= 1'b0;
            b3_re_reg    <= 1'b0;
            b4_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            b1_valid_reg <= q_valid;
            b2_valid_reg <= b1_valid_reg;
            b3_valid_reg <= b2_valid_reg && (b2_kind_reg != rim_pkg::KIND_WRITE);
            b3_we_reg    <= b2_valid_reg && (b2_kind_reg == rim_pkg::KIND_WRITE);
            b3_re_reg    <= b2_valid_reg && (b2_kind_reg == rim_pkg::KIND_MAP) && hit;
            b4_valid_reg <= b3_valid_reg;
            done_reg     <= b4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        b1_kind_reg  <= q_ent.kind;
        b1_waddr_reg <= q_waddr;
        b1_pixel_reg <= q_ent.pixel;
        b1_ic_reg    <= q_ent.i * geom.cosv;
        b1_js_reg    <= q_ent.j * geom.sinv;
        b1_is_reg    <= q_ent.i * geom.sinv;
        b1_jc_reg    <= q_ent.j * geom.cosv;
    end

    always_ff @(posedge clk)
    begin
        b2_kind_reg  <= b1_kind_reg;
        b2_waddr_reg <= b1_waddr_reg;
        b2_pixel_reg <= b1_pixel_reg;
        b2_nx_reg    <= MAP_W'(rim_pkg::q14_trunc(32'(b1_ic_reg) - 32'(b1_js_reg)));
        b2_ny_reg    <= MAP_W'(rim_pkg::q14_trunc(32'(b1_is_reg) + 32'(b1_jc_reg)));
    end

    always_comb
    begin
        hit = !b2_nx_reg[MAP_W-1] && ($unsigned(b2_nx_reg) < MAP_W'(geom.w))
           && !b2_ny_reg[MAP_W-1] && ($unsigned(b2_ny_reg) < MAP_W'(geom.h));
        map_addr = ADDR_W'(ADDR_W'($unsigned(b2_ny_reg)) * ADDR_W'(MAX_SIDE)
                 + ADDR_W'($unsigned(b2_nx_reg)));
        b3_addr_next = (b2_kind_reg == rim_pkg::KIND_WRITE) ? b2_waddr_reg : map_addr;
        unique case (b2_kind_reg)
            rim_pkg::KIND_MAP: b3_status_next = hit ? rim_pkg::ST_COPY : rim_pkg::ST_BG;
            default:           b3_status_next = rim_pkg::ST_OUTSIDE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        b3_addr_reg   <= b3_addr_next;
        b3_pixel_reg  <= b2_pixel_reg;
        b3_status_reg <= b3_status_next;
    end

    always_ff @(posedge clk)
    begin
        if (b3_we_reg)
        begin
            mem[b3_addr_reg] <= b3_pixel_reg;
        end
        if (b3_re_reg)
        begin
            rdata_reg <= mem[b3_addr_reg];
        end
        b4_status_reg <= b3_status_reg;
    end

    always_comb
    begin
        unique case (b4_status_reg)
            rim_pkg::ST_COPY: pixel_next = rdata_reg;
            rim_pkg::ST_BG:   pixel_next = geom.bg_pixel;
            default:          pixel_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        pixel_reg  <= pixel_next;
        status_reg <= b4_status_reg;
        width_reg  <= (geom.nw > BOX_W'(rim_pkg::OUT_MAX)) ? rim_pkg::OUT_MAX
                                                            : OUT_W'(geom.nw);
        height_reg <= (geom.nh > BOX_W'(rim_pkg::OUT_MAX)) ? rim_pkg::OUT_MAX
                                                            : OUT_W'(geom.nh);
    end

    assign done       = done_reg;
    assign pixel_out  = pixel_reg;
    assign status     = status_reg;
    assign out_width  = width_reg;
    assign out_height = height_reg;

endmodule

[rtl/image_rotation_inverse_map_top.sv]
// Nearest-neighbor image rotation by inverse mapping.
// Request channel: drive start with command, column, line and pixel_in; the
// request is taken at a rising edge where start is high and busy is low.
// A write request stores pixel_in at (column, line) and gives no result; writes
// outside the store are dropped. A read request names an output pixel and
// gives exactly one result: done is high for one cycle with pixel_out, status,
// out_width and out_height. The receiver cannot stall, so results never wait.
// Throughput is one request per cycle while busy is low. A read result passes
// in order through the front register, the request queue, the two-stage
// product and truncation path, the map stage, the registered pixel store
// read and the output register.
// Configuration goes through the APB port, one register per 32-bit word;
// write only while no read is in flight. After each register write and after
// reset, busy stays high while the bounding box pipeline settles.
// Reset restores a 128x128 source, zero rotation and black background; the
// pixel store is not cleared, so read only pixels that were written.
module image_rotation_inverse_map_top #(
    parameter int MAX_SIDE = 128
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               command,
    input  logic [7:0]                         column,
    input  logic [7:0]                         line,
    input  logic [rim_pkg::PIX_W-1:0]          pixel_in,
    output logic                               done,
    output logic [rim_pkg::PIX_W-1:0]          pixel_out,
    output logic [rim_pkg::ST_W-1:0]           status,
    output logic [rim_pkg::OUT_W-1:0]          out_width,
    output logic [rim_pkg::OUT_W-1:0]          out_height,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [rim_pkg::REG_ADDR_W-1:0]     paddr,
    input  logic [rim_pkg::DATA_W-1:0]         pwdata,
    output logic [rim_pkg::DATA_W-1:0]         prdata,
    output logic                               pready
);

    localparam int ADDR_W  = $clog2(MAX_SIDE * MAX_SIDE);
    localparam int ENT_W   = $bits(rim_pkg::qent_t);
    localparam int Q_W     = ENT_W + ADDR_W;
    localparam int LATENCY = 7;

    rim_pkg::geom_t     geom;
    rim_pkg::qent_t     push_ent;
    rim_pkg::qent_t     head_ent;
    logic               settle;
    logic               q_almost_full;
    logic               push;
    logic [ADDR_W-1:0]  push_waddr;
    logic               q_valid;
    logic               q_pop;
    logic [Q_W-1:0]     q_rdata;

    assign pready   = 1'b1;
    assign head_ent = rim_pkg::qent_t'(q_rdata[Q_W-1:ADDR_W]);

    rim_geom #(
        .MAX_SIDE (MAX_SIDE)
    ) u_geom (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .geom    (geom),
        .settle  (settle)
    );

    rim_front #(
        .MAX_SIDE (MAX_SIDE),
        .ADDR_W   (ADDR_W)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .command       (command),
        .column        (column),
        .line          (line),
        .pixel_in      (pixel_in),
        .geom          (geom),
        .settle        (settle),
        .q_almost_full (q_almost_full),
        .push          (push),
        .push_ent      (push_ent),
        .push_waddr    (push_waddr)
    );

    rim_queue #(
        .WIDTH (Q_W),
        .DEPTH (rim_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .wdata       ({push_ent, push_waddr}),
        .pop         (q_pop),
        .rd_valid    (q_valid),
        .rdata       (q_rdata),
        .almost_full (q_almost_full)
    );

    rim_back #(
        .MAX_SIDE (MAX_SIDE),
        .ADDR_W   (ADDR_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_ent      (head_ent),
        .q_waddr    (q_rdata[ADDR_W-1:0]),
        .q_pop      (q_pop),
        .geom       (geom),
        .done       (done),
        .pixel_out  (pixel_out),
        .status     (status),
        .out_width  (out_width),
        .out_height (out_height)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && command == rim_pkg::CMD_READ) |-> ##LATENCY done)
        else $error("read request produced no result");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy && command == rim_pkg::CMD_READ, LATENCY))
        else $error("result without a matching read request");

    assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite) |=> busy)
        else $error("request taken while geometry settles");

endmodule
